FILE: rtl/core/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Types and constants shared by the skeleton to gap record converter.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned LEN_W  = 34;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned EX_W   = POS_W + 4;

  // codon mode register codes
  localparam logic [MODE_W-1:0] MODE_NUC     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_A_CODON = 2'd1;
  localparam logic [MODE_W-1:0] MODE_B_CODON = 2'd2;

  // record kinds in emission order
  localparam logic [2:0] SLOT_START_A = 3'd0;
  localparam logic [2:0] SLOT_START_B = 3'd1;
  localparam logic [2:0] SLOT_GAP     = 3'd2;
  localparam logic [2:0] SLOT_END_A   = 3'd3;
  localparam logic [2:0] SLOT_END_B   = 3'd4;

  typedef struct packed {
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic             is_last;
  } point_t;

  typedef struct packed {
    logic             which_seq;
    logic [POS_W-1:0] gap_pos;
    logic [LEN_W-1:0] gap_len;
    logic [LEN_W-1:0] aligned_span;
    logic             path_end;
    logic             order_error;
    logic             last_of_run;
  } rec_t;

  typedef struct packed {
    logic             expect_first;
    logic [POS_W-1:0] prev_a;
    logic [POS_W-1:0] prev_b;
    logic [LEN_W-1:0] span;
  } state_t;

  // all records caused by one point
  typedef struct packed {
    logic             first;
    logic             gap;
    logic             last;
    logic             gap_seq;
    logic             err;
    logic [1:0]       last_idx;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic [LEN_W-1:0] gap_len;
    logic [LEN_W-1:0] span;
  } bundle_t;

endpackage

FILE: rtl/core/skeleton_to_gap_records.sv
// ----------------------------------------------------------------------------
// skeleton_to_gap_records
// Turns alignment path corner points into start, gap and end records.
// ----------------------------------------------------------------------------
// first record of a point is offered in the cycle after the point is taken
// throughput: one point per cycle while each point yields at most one record and
//   rec_ready is high; otherwise a point waits on the single record output port
// reset: codon_mode 0, awaiting path start, no record pending
// ----------------------------------------------------------------------------
module skeleton_to_gap_records (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sgr_pkg::MODE_W-1:0] cfg_data,
  input  logic                       point_valid,
  output logic                       point_ready,
  input  sgr_pkg::point_t            point,
  output logic                       rec_valid,
  input  logic                       rec_ready,
  output sgr_pkg::rec_t              rec
);

  logic [sgr_pkg::MODE_W-1:0] mode;
  sgr_pkg::state_t            st;
  sgr_pkg::state_t            st_next;
  sgr_pkg::bundle_t           bundle;
  sgr_pkg::bundle_t           bundle_next;
  logic                       bvalid;
  logic [1:0]                 k;
  logic                       has_rec;
  logic                       rec_done;
  logic                       accept;
  logic [2:0]                 slot;

  sgr_point_calc u_calc (
    .mode    (mode),
    .pt      (point),
    .st      (st),
    .bundle  (bundle_next),
    .has_rec (has_rec),
    .st_next (st_next)
  );

  assign cfg_ready   = 1'b1;
  assign rec_done    = bvalid && rec_ready && (k == bundle.last_idx);
  assign point_ready = !bvalid || rec_done;
  assign accept      = point_valid && point_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= sgr_pkg::MODE_NUC;
      st.expect_first <= 1'b1;
      st.prev_a       <= '0;
      st.prev_b       <= '0;
      st.span         <= '0;
      bvalid          <= 1'b0;
      k               <= '0;
    end else begin
      if (cfg_valid) begin
        mode <= cfg_data;
      end
      if (accept) begin
        st     <= st_next;
        bvalid <= has_rec;
        k      <= '0;
      end else if (rec_done) begin
        bvalid <= 1'b0;
        k      <= '0;
      end else if (bvalid && rec_ready) begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bundle <= bundle_next;
    end
  end

  // map record index to record kind
  always_comb begin
    if (bundle.first) begin
      slot = (k < 2'd2) ? {1'b0, k} : ({1'b0, k} + 3'd1);
    end else if (bundle.gap) begin
      slot = (k == 2'd0) ? sgr_pkg::SLOT_GAP : ({1'b0, k} + 3'd2);
    end else begin
      slot = {1'b0, k} + 3'd3;
    end
  end

  always_comb begin
    rec.gap_len      = '0;
    rec.aligned_span = bundle.span;
    rec.path_end     = 1'b0;
    rec.order_error  = bundle.err;
    rec.last_of_run  = (k == bundle.last_idx);
    unique case (slot)
      sgr_pkg::SLOT_START_A: begin
        rec.which_seq    = 1'b0;
        rec.gap_pos      = bundle.pos_a;
        rec.aligned_span = '0;
      end
      sgr_pkg::SLOT_START_B: begin
        rec.which_seq    = 1'b1;
        rec.gap_pos      = bundle.pos_b;
        rec.aligned_span = '0;
      end
      sgr_pkg::SLOT_GAP: begin
        rec.which_seq = bundle.gap_seq;
        rec.gap_pos   = bundle.gap_seq ? bundle.pos_b : bundle.pos_a;
        rec.gap_len   = bundle.gap_len;
      end
      sgr_pkg::SLOT_END_A: begin
        rec.which_seq = 1'b0;
        rec.gap_pos   = bundle.pos_a;
        rec.path_end  = 1'b1;
      end
      default: begin
        rec.which_seq = 1'b1;
        rec.gap_pos   = bundle.pos_b;
        rec.path_end  = 1'b1;
      end
    endcase
  end

  assign rec_valid = bvalid;

endmodule

FILE: rtl/core/sgr_point_calc.sv
// ----------------------------------------------------------------------------
// sgr_point_calc
// Differences, diagonal excess and span update for one corner point.
// ----------------------------------------------------------------------------
module sgr_point_calc (
  input  logic [sgr_pkg::MODE_W-1:0] mode,
  input  sgr_pkg::point_t            pt,
  input  sgr_pkg::state_t            st,
  output sgr_pkg::bundle_t           bundle,
  output logic                       has_rec,
  output sgr_pkg::state_t            st_next
);

  logic [sgr_pkg::DIFF_W-1:0] da;
  logic [sgr_pkg::DIFF_W-1:0] db;
  logic [sgr_pkg::EX_W-1:0]   da_x;
  logic [sgr_pkg::EX_W-1:0]   db_x;
  logic [sgr_pkg::EX_W-1:0]   ex;
  logic [sgr_pkg::EX_W-1:0]   ex_neg;
  logic [sgr_pkg::LEN_W-1:0]  mag;
  logic [sgr_pkg::LEN_W-1:0]  match_len;
  logic [sgr_pkg::LEN_W-1:0]  span_sum;
  logic                       ex_zero;
  logic                       err;

  assign da   = {1'b0, pt.pos_a} - {1'b0, st.prev_a};
  assign db   = {1'b0, pt.pos_b} - {1'b0, st.prev_b};
  assign da_x = {{(sgr_pkg::EX_W-sgr_pkg::DIFF_W){da[sgr_pkg::DIFF_W-1]}}, da};
  assign db_x = {{(sgr_pkg::EX_W-sgr_pkg::DIFF_W){db[sgr_pkg::DIFF_W-1]}}, db};
  assign err  = da[sgr_pkg::DIFF_W-1] | db[sgr_pkg::DIFF_W-1];

  always_comb begin
    unique case (mode)
      sgr_pkg::MODE_NUC: begin
        ex = da_x - db_x;
      end
      sgr_pkg::MODE_A_CODON: begin
        ex = {da_x[sgr_pkg::EX_W-2:0], 1'b0} + da_x - db_x;
      end
      default: begin
        ex = da_x - {db_x[sgr_pkg::EX_W-2:0], 1'b0} - db_x;
      end
    endcase
  end

  assign ex_zero   = (ex == '0);
  assign ex_neg    = ~ex + 1'b1;
  assign mag       = ex[sgr_pkg::EX_W-1] ? ex_neg[sgr_pkg::LEN_W-1:0]
                                         : ex[sgr_pkg::LEN_W-1:0];
  assign match_len = (mode == sgr_pkg::MODE_A_CODON) ? {db[sgr_pkg::DIFF_W-1], db}
                                                      : {da[sgr_pkg::DIFF_W-1], da};
  assign span_sum  = st.span + (ex_zero ? match_len : mag);

  always_comb begin
    bundle.first   = st.expect_first;
    bundle.gap     = !st.expect_first && !ex_zero;
    bundle.last    = pt.is_last;
    bundle.gap_seq = !ex[sgr_pkg::EX_W-1];
    bundle.err     = !st.expect_first && err;
    bundle.pos_a   = pt.pos_a;
    bundle.pos_b   = pt.pos_b;
    bundle.gap_len = mag;
    bundle.span    = st.expect_first ? '0 : span_sum;
    if (st.expect_first) begin
      bundle.last_idx = pt.is_last ? 2'd3 : 2'd1;
    end else if (!ex_zero) begin
      bundle.last_idx = pt.is_last ? 2'd2 : 2'd0;
    end else begin
      bundle.last_idx = 2'd1;
    end
    has_rec = st.expect_first || !ex_zero || pt.is_last;

    st_next.expect_first = pt.is_last;
    st_next.prev_a       = pt.pos_a;
    st_next.prev_b       = pt.pos_b;
    st_next.span         = bundle.span;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the skeleton to gap record converter.
// Corner points go in through a valid/ready driver, a tracker in the bench
// works out the start, gap and end records that each point must give, and a
// monitor compares every record that comes out, field by field. The codon mode
// register is rewritten between phases while the block is idle, and the two
// sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [sgr_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic              SEQ_A       = 1'b0;
  localparam logic              SEQ_B       = 1'b1;
  localparam int                STALL_LIMIT = 2000;
  localparam int                SETTLE      = 4;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       cfg_valid   = 1'b0;
  logic                       cfg_ready;
  logic [sgr_pkg::MODE_W-1:0] cfg_data    = '0;
  logic                       point_valid = 1'b0;
  logic                       point_ready;
  sgr_pkg::point_t            point       = '0;
  logic                       rec_valid;
  logic                       rec_ready   = 1'b0;
  sgr_pkg::rec_t              rec;

  sgr_pkg::point_t   pending_points [$];
  sgr_pkg::rec_t     recs_due [$];
  logic              point_took    = 1'b0;
  int                send_idle_pct = 31;
  int                recv_idle_pct = 47;
  int                points_queued = 0;
  int                points_taken  = 0;
  int                paths_closed  = 0;
  int                recs_checked  = 0;
  int                fails         = 0;
  int                stall_cycles  = 0;

  // tracked block state
  logic                       trk_first = 1'b1;
  logic [sgr_pkg::POS_W-1:0]  trk_prev_a = '0;
  logic [sgr_pkg::POS_W-1:0]  trk_prev_b = '0;
  logic [sgr_pkg::LEN_W-1:0]  trk_span = '0;
  logic [sgr_pkg::MODE_W-1:0] trk_mode = sgr_pkg::MODE_NUC;

  skeleton_to_gap_records dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point),
    .rec_valid   (rec_valid),
    .rec_ready   (rec_ready),
    .rec         (rec)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic sgr_pkg::rec_t make_rec(logic seq, logic [sgr_pkg::POS_W-1:0] pos,
                                             logic [sgr_pkg::LEN_W-1:0] len,
                                             logic [sgr_pkg::LEN_W-1:0] span,
                                             logic is_end, logic err);
    sgr_pkg::rec_t r;
    r.which_seq    = seq;
    r.gap_pos      = pos;
    r.gap_len      = len;
    r.aligned_span = span;
    r.path_end     = is_end;
    r.order_error  = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic void predict_records(sgr_pkg::point_t p);
    sgr_pkg::rec_t             out [4];
    int                        n;
    longint                    da;
    longint                    db;
    longint                    ex;
    logic                      err;
    logic [sgr_pkg::LEN_W-1:0] mag;
    n   = 0;
    err = 1'b0;
    if (trk_first) begin
      trk_span = '0;
      out[0] = make_rec(SEQ_A, p.pos_a, '0, '0, 1'b0, 1'b0);
      out[1] = make_rec(SEQ_B, p.pos_b, '0, '0, 1'b0, 1'b0);
      n = 2;
    end else begin
      da  = longint'({32'd0, p.pos_a}) - longint'({32'd0, trk_prev_a});
      db  = longint'({32'd0, p.pos_b}) - longint'({32'd0, trk_prev_b});
      err = (da < 0) || (db < 0);
      case (trk_mode)
        sgr_pkg::MODE_NUC:     ex = da - db;
        sgr_pkg::MODE_A_CODON: ex = 3 * da - db;
        default:               ex = da - 3 * db;
      endcase
      if (ex < 0) begin
        mag = sgr_pkg::LEN_W'(-ex);
        trk_span = trk_span + mag;
        out[0] = make_rec(SEQ_A, p.pos_a, mag, trk_span, 1'b0, err);
        n = 1;
      end else if (ex > 0) begin
        mag = sgr_pkg::LEN_W'(ex);
        trk_span = trk_span + mag;
        out[0] = make_rec(SEQ_B, p.pos_b, mag, trk_span, 1'b0, err);
        n = 1;
      end else begin
        // matched stretch, may be negative when coordinates go backwards
        trk_span = trk_span +
                   sgr_pkg::LEN_W'((trk_mode == sgr_pkg::MODE_A_CODON) ? db : da);
      end
    end
    trk_prev_a = p.pos_a;
    trk_prev_b = p.pos_b;
    if (p.is_last) begin
      out[n]     = make_rec(SEQ_A, p.pos_a, '0, trk_span, 1'b1, err);
      out[n + 1] = make_rec(SEQ_B, p.pos_b, '0, trk_span, 1'b1, err);
      n = n + 2;
    end
    trk_first = p.is_last;
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        out[i].last_of_run = 1'b1;
      end
      recs_due.push_back(out[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_record(sgr_pkg::rec_t got);
    sgr_pkg::rec_t want;
    if (recs_due.size() == 0) begin
      $error("record with none pending: %p", got);
      fails++;
      return;
    end
    want = recs_due.pop_front();
    recs_checked++;
    check_field("which_seq", 64'(want.which_seq), 64'(got.which_seq));
    check_field("gap_pos", 64'(want.gap_pos), 64'(got.gap_pos));
    check_field("gap_len", 64'(want.gap_len), 64'(got.gap_len));
    check_field("aligned_span", 64'(want.aligned_span), 64'(got.aligned_span));
    check_field("path_end", 64'(want.path_end), 64'(got.path_end));
    check_field("order_error", 64'(want.order_error), 64'(got.order_error));
    check_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
  endfunction

  // point driver
  always @(negedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (!point_valid || point_took) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        point       <= pending_points.pop_front();
        point_valid <= 1'b1;
      end else begin
        point_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rec_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    point_took <= !rst && point_valid && point_ready;
    if (!rst) begin
      if (rec_valid && rec_ready) begin
        check_record(rec);
      end
      if (point_valid && point_ready) begin
        predict_records(point);
        points_taken++;
        if (point.is_last) begin
          paths_closed++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((point_valid && point_ready) || (rec_valid && rec_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void queue_point(logic [sgr_pkg::POS_W-1:0] a,
                                      logic [sgr_pkg::POS_W-1:0] b, logic last);
    sgr_pkg::point_t p;
    p.pos_a   = a;
    p.pos_b   = b;
    p.is_last = last;
    pending_points.push_back(p);
    points_queued++;
  endfunction

  // mostly well-formed paths, some loose random points
  function automatic void queue_random(int count, logic [sgr_pkg::MODE_W-1:0] mode);
    int                        left;
    int                        len;
    int                        k;
    logic [sgr_pkg::POS_W-1:0] a;
    logic [sgr_pkg::POS_W-1:0] b;
    left = count;
    while (left > 0) begin
      if ($urandom_range(99) < 20) begin
        queue_point($urandom, $urandom, 1'($urandom_range(1)));
        left--;
      end else begin
        len = $urandom_range(1, 8);
        a   = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000);
        b   = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000);
        for (int i = 0; i < len; i++) begin
          if (i > 0) begin
            k = $urandom_range(1, 50);
            case ($urandom_range(4))
              0, 1: begin
                if (mode == sgr_pkg::MODE_NUC) begin
                  a = a + k;
                  b = b + k;
                end else if (mode == sgr_pkg::MODE_A_CODON) begin
                  a = a + k;
                  b = b + 3 * k;
                end else begin
                  a = a + 3 * k;
                  b = b + k;
                end
              end
              2: begin
                a = a + $urandom_range(20);
                b = b + $urandom_range(200);
              end
              3: begin
                a = a + $urandom_range(200);
                b = b + $urandom_range(20);
              end
              default: begin
                a = a + $urandom;
                b = b + $urandom;
              end
            endcase
          end
          queue_point(a, b, i == len - 1);
          left--;
        end
      end
    end
  endfunction

  task automatic write_mode(logic [sgr_pkg::MODE_W-1:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    trk_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    do @(negedge clk); while (points_taken != points_queued || recs_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    write_mode(sgr_pkg::MODE_NUC);
    @(posedge clk);

    // small path: start, matched run, gap in B, gap in A, matched end
    queue_point(32'd0, 32'd0, 1'b0);
    queue_point(32'd10, 32'd10, 1'b0);
    queue_point(32'd15, 32'd12, 1'b0);
    queue_point(32'd16, 32'd20, 1'b0);
    queue_point(32'd16, 32'd20, 1'b1);
    // single point path at the top of the range
    queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // full range swings, backwards steps and span wrap
    queue_point(32'd0, 32'd0, 1'b0);
    queue_point(32'hFFFF_FFFF, 32'd0, 1'b0);
    queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_point(32'd0, 32'hFFFF_FFFF, 1'b0);
    queue_point(32'hFFFF_FFFF, 32'd0, 1'b0);
    queue_point(32'd0, 32'd0, 1'b0);
    queue_point(32'd5, 32'd5, 1'b0);
    queue_point(32'd3, 32'd3, 1'b1);
    // alternating bit patterns
    queue_point(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    queue_point(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    drain();

    write_mode(sgr_pkg::MODE_A_CODON);
    @(posedge clk);
    queue_random(12, sgr_pkg::MODE_A_CODON);
    // hold the points back until every record so far is out
    drain();
    queue_random(13, sgr_pkg::MODE_A_CODON);
    drain();

    send_idle_pct = 47;
    recv_idle_pct = 31;
    write_mode(sgr_pkg::MODE_B_CODON);
    @(posedge clk);
    queue_random(25, sgr_pkg::MODE_B_CODON);
    drain();

    write_mode(MODE_UNUSED);
    @(posedge clk);
    queue_random(25, MODE_UNUSED);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(sgr_pkg::MODE_NUC);
    @(posedge clk);
    queue_random(25, sgr_pkg::MODE_NUC);
    drain();

    $display("%0d points in %0d closed paths, %0d records checked", points_taken, paths_closed,
             recs_checked);
    $display("codon modes 0 to 3 written, with and without stalls on both sides");
    if (fails == 0 && recs_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sgr_pkg.sv
rtl/core/sgr_point_calc.sv
rtl/core/skeleton_to_gap_records.sv
tb/tb.sv
